/* src/cts_pkg.sv */
`timescale 1ns / 1ps

package cts_pkg;

    // datapath geometry
    localparam int STAGES    = 8;
    localparam int SAMPLE_W  = 24;
    localparam int STATE_W   = 40;
    localparam int FRAC_W    = STATE_W - SAMPLE_W;
    localparam int COEF_W    = 25;
    localparam int MIX_W     = 17;
    localparam int CF_W      = COEF_W + 1;
    localparam int COEF_SH   = 24;
    localparam int MIX_SH    = 16;

    // split multiply: low half zero-extended, high half signed
    localparam int LO_W      = STATE_W / 2;
    localparam int OPD_W     = LO_W + 1;
    localparam int PROD_W    = OPD_W + CF_W;
    localparam int ACC_W     = STATE_W + CF_W + 1;
    localparam int MUL_STEPS = 4;
    localparam int SHR_W     = ACC_W - COEF_SH;
    localparam int YW        = ACC_W - MIX_SH;
    localparam int ZW        = YW - FRAC_W;

    localparam int STG_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int ADDR_W    = STG_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = COEF_W;

    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << COEF_SH);
    localparam logic [CF_W-1:0]   K0999     = CF_W'(16760439);
    localparam logic [MIX_W-1:0]  WET_ONE   = MIX_W'(1 << MIX_SH);
    localparam logic [MIX_W-1:0]  WET_RESET = MIX_W'(1 << (MIX_SH - 1));
    localparam logic [YW-1:0]     RND_OUT   =
        (FRAC_W > 0) ? (YW'(1) << (FRAC_W - 1)) : '0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [STATE_W-1:0]  t_state;
    typedef logic signed [CF_W-1:0]     t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [ADDR_W-1:0]          t_addr;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA  = 3'd0,
        REG_BETA   = 3'd1,
        REG_WET    = 3'd2,
        REG_BYPASS = 3'd3,
        REG_MONO   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_mem_rd;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_state prev;
        t_state trend;
    } t_mem_wr;

    typedef struct packed {
        logic   start;
        logic   mix;
        t_state v1;
        t_coef  c1;
        t_state v2;
        t_coef  c2;
    } t_blend_req;

    function automatic t_state sat_state(input logic [SHR_W-1:0] v);
        logic ovf;
        ovf = (v[SHR_W-1:STATE_W-1] != {(SHR_W-STATE_W+1){v[SHR_W-1]}});
        if (!ovf) begin
            sat_state = v[STATE_W-1:0];
        end else if (v[SHR_W-1]) begin
            sat_state = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            sat_state = {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

    function automatic t_sample sat_sample(input logic [ZW-1:0] v);
        logic ovf;
        ovf = (v[ZW-1:SAMPLE_W-1] != {(ZW-SAMPLE_W+1){v[ZW-1]}});
        if (!ovf) begin
            sat_sample = v[SAMPLE_W-1:0];
        end else if (v[ZW-1]) begin
            sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

/* src/cts_in_if.sv */
`timescale 1ns / 1ps

interface cts_in_if;
    logic             valid;
    logic             ready;
    cts_pkg::t_sample left_sample;
    cts_pkg::t_sample right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* src/cts_out_if.sv */
`timescale 1ns / 1ps

interface cts_out_if;
    logic             valid;
    logic             ready;
    cts_pkg::t_sample left_out;
    cts_pkg::t_sample right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* src/cts_state_mem.sv */
`timescale 1ns / 1ps

module cts_state_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cts_pkg::t_mem_rd  i_rd,
    input  cts_pkg::t_mem_wr  i_wr,
    output cts_pkg::t_state   o_prev,
    output cts_pkg::t_state   o_trend
);
    import cts_pkg::*;

    logic [2*STATE_W-1:0] r_mem [MEM_DEPTH];
    logic [2*STATE_W-1:0] r_rdata;
    logic [MEM_DEPTH-1:0] r_vld;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.prev, i_wr.trend};
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rvld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_prev  = r_rvld ? r_rdata[2*STATE_W-1:STATE_W] : '0;
    assign o_trend = r_rvld ? r_rdata[STATE_W-1:0] : '0;

endmodule

/* src/cts_blend.sv */
`timescale 1ns / 1ps

module cts_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cts_pkg::t_blend_req i_req,
    output logic                o_done,
    output cts_pkg::t_acc       o_acc
);
    import cts_pkg::*;

    t_state                    r_v1;
    t_state                    r_v2;
    t_coef                     r_c1;
    t_coef                     r_c2;
    logic [1:0]                r_k;
    logic                      r_busy;
    logic                      r_pvld;
    logic                      r_plast;
    logic                      r_phi;
    logic                      r_done;
    logic signed [PROD_W-1:0]  r_prod;
    t_acc                      r_acc;

    t_state                    sel_v;
    t_coef                     sel_c;
    logic signed [OPD_W-1:0]   opd;
    logic signed [PROD_W-1:0]  prod;
    t_acc                      addend;
    t_acc                      rnd;

    // step k: bit 1 picks the operand pair, bit 0 the half
    always_comb begin
        sel_v = r_k[1] ? r_v2 : r_v1;
        sel_c = r_k[1] ? r_c2 : r_c1;
        if (r_k[0]) begin
            opd = {{(OPD_W-(STATE_W-LO_W)){sel_v[STATE_W-1]}}, sel_v[STATE_W-1:LO_W]};
        end else begin
            opd = {{(OPD_W-LO_W){1'b0}}, sel_v[LO_W-1:0]};
        end
        prod   = opd * sel_c;
        addend = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (r_phi) begin
            addend = addend <<< LO_W;
        end
        rnd = i_req.mix ? (ACC_W'(1) << (MIX_SH - 1)) : (ACC_W'(1) << (COEF_SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_pvld  <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_pvld  <= r_busy;
            r_plast <= r_busy && (r_k == 2'(MUL_STEPS - 1));
            r_done  <= r_pvld && r_plast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v1  <= i_req.v1;
            r_v2  <= i_req.v2;
            r_c1  <= i_req.c1;
            r_c2  <= i_req.c2;
            r_acc <= rnd;
        end else if (r_pvld) begin
            r_acc <= r_acc + addend;
        end
        if (r_busy) begin
            r_prod <= prod;
            r_phi  <= r_k[0];
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

/* src/cascaded_trend_smoother_stereo_core.sv */
`timescale 1ns / 1ps

// sequence: each item runs 16 stage passes (read, operand prep, 4 split multiplies plus
//   accumulate drain) and two mix passes; in bypass it goes straight to the output register
// a new item is taken only once the previous result is loaded into the output register
// reset: synchronous active low; clears control, config to defaults, state entry valid bits
module cascaded_trend_smoother_stereo_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cts_pkg::CFG_W-1:0]             i_cfg_data,
    cts_in_if.sink                                i_in,
    cts_out_if.source                             o_out
);
    import cts_pkg::*;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_MIXGO = 7'b0010000,
        ST_MIXW  = 7'b0100000,
        ST_PUT   = 7'b1000000
    } t_fsm;

    t_fsm              r_fsm;
    t_fsm              n_fsm;

    // configuration registers
    logic [COEF_W-1:0] r_alpha;
    logic [COEF_W-1:0] r_beta;
    logic [MIX_W-1:0]  r_wet;
    logic              r_bypass;
    logic              r_mono;

    // per-item working registers
    t_sample           r_dry_l;
    t_sample           r_dry_r;
    logic              r_ch;
    logic [STG_W-1:0]  r_stg;
    t_state            r_x;
    t_sample           r_yl;
    t_sample           r_yr;

    // output register
    logic              r_out_vld;
    t_sample           r_out_l;
    t_sample           r_out_r;

    // coefficient and mix weight terms
    logic [COEF_W-1:0] a_cl;
    logic [COEF_W-1:0] b_cl;
    logic [MIX_W-1:0]  w_cl;
    t_coef             c_a;
    t_coef             c_ka;
    t_coef             c_b;
    t_coef             c_kb;
    t_coef             c_w;
    t_coef             c_nw;
    logic              pass_thru;

    t_mem_rd           mem_rd;
    t_mem_wr           mem_wr;
    t_state            mem_prev;
    t_state            mem_trend;

    t_blend_req        req_t;
    t_blend_req        req_x;
    logic              done_t;
    logic              done_x;
    t_acc              acc_t;
    t_acc              acc_x;

    logic              in_xfer;
    logic              out_xfer;
    logic              out_load;
    t_sample           dry_cur;
    t_sample           right_src;
    t_state            dry_st;
    t_state            d_val;
    t_state            f_val;
    t_state            t_new;
    t_state            x_new;
    logic [YW-1:0]     y_rnd;
    t_sample           y_out;

    cts_state_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (mem_rd),
        .i_wr    (mem_wr),
        .o_prev  (mem_prev),
        .o_trend (mem_trend)
    );

    // trend blend unit
    cts_blend u_blend_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_t),
        .o_done  (done_t),
        .o_acc   (acc_t)
    );

    // forecast blend unit, also does the wet/dry mix
    cts_blend u_blend_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_x),
        .o_done  (done_x),
        .o_acc   (acc_x)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_beta   <= '0;
            r_wet    <= WET_RESET;
            r_bypass <= 1'b0;
            r_mono   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ALPHA:  r_alpha  <= i_cfg_data[COEF_W-1:0];
                REG_BETA:   r_beta   <= i_cfg_data[COEF_W-1:0];
                REG_WET:    r_wet    <= i_cfg_data[MIX_W-1:0];
                REG_BYPASS: r_bypass <= i_cfg_data[0];
                REG_MONO:   r_mono   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // coefficients above one act as one; 0.999 - coef may go negative
    always_comb begin
        a_cl      = (r_alpha > COEF_ONE) ? COEF_ONE : r_alpha;
        b_cl      = (r_beta > COEF_ONE) ? COEF_ONE : r_beta;
        w_cl      = (r_wet > WET_ONE) ? WET_ONE : r_wet;
        c_a       = {1'b0, a_cl};
        c_b       = {1'b0, b_cl};
        c_ka      = K0999 - c_a;
        c_kb      = K0999 - c_b;
        c_w       = {{(CF_W-MIX_W){1'b0}}, w_cl};
        c_nw      = {{(CF_W-MIX_W){1'b0}}, WET_ONE - w_cl};
        pass_thru = r_bypass || (r_wet == '0);
    end

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_xfer  = r_out_vld && o_out.ready;
    assign out_load  = (r_fsm == ST_PUT) && (!r_out_vld || o_out.ready);
    assign i_in.ready = (r_fsm == ST_IDLE);
    assign right_src = r_mono ? i_in.left_sample : i_in.right_sample;

    // stage datapath: differences off the registered memory read
    always_comb begin
        dry_cur = r_ch ? r_dry_r : r_dry_l;
        dry_st  = t_state'(dry_cur) <<< FRAC_W;
        d_val   = sat_state(SHR_W'(r_x) - SHR_W'(mem_prev));
        f_val   = sat_state(SHR_W'(mem_prev) + SHR_W'(mem_trend));
        t_new   = sat_state(acc_t[ACC_W-1:COEF_SH]);
        x_new   = sat_state(acc_x[ACC_W-1:COEF_SH]);
        // mix result: round at 16 bits, then back to sample scale
        y_rnd   = acc_x[ACC_W-1:MIX_SH] + RND_OUT;
        y_out   = sat_sample(y_rnd[YW-1:FRAC_W]);
    end

    // blend requests
    always_comb begin
        req_t.start = (r_fsm == ST_PREP);
        req_t.mix   = 1'b0;
        req_t.v1    = d_val;
        req_t.c1    = c_b;
        req_t.v2    = mem_trend;
        req_t.c2    = c_kb;

        req_x.start = (r_fsm == ST_PREP) || (r_fsm == ST_MIXGO);
        req_x.mix   = (r_fsm == ST_MIXGO);
        req_x.v1    = r_x;
        if (r_fsm == ST_MIXGO) begin
            req_x.c1 = c_w;
            req_x.v2 = dry_st;
            req_x.c2 = c_nw;
        end else begin
            req_x.c1 = c_a;
            req_x.v2 = f_val;
            req_x.c2 = c_ka;
        end
    end

    // state memory: entry {channel, stage}, read-modify-write once per item
    always_comb begin
        mem_rd.en    = (r_fsm == ST_RD);
        mem_rd.addr  = {r_ch, r_stg};
        mem_wr.en    = (r_fsm == ST_MUL) && done_t;
        mem_wr.addr  = {r_ch, r_stg};
        mem_wr.prev  = x_new;
        mem_wr.trend = t_new;
    end

    // sequencer next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_fsm = pass_thru ? ST_PUT : ST_RD;
                end
            end
            ST_RD:    n_fsm = ST_PREP;
            ST_PREP:  n_fsm = ST_MUL;
            ST_MUL: begin
                if (done_t) begin
                    n_fsm = (r_stg == STG_W'(STAGES - 1)) ? ST_MIXGO : ST_RD;
                end
            end
            ST_MIXGO: n_fsm = ST_MIXW;
            ST_MIXW: begin
                if (done_x) begin
                    n_fsm = r_ch ? ST_PUT : ST_RD;
                end
            end
            ST_PUT: begin
                if (out_load) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_ch      <= 1'b0;
            r_stg     <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
            if (in_xfer) begin
                r_ch  <= 1'b0;
                r_stg <= '0;
            end else if ((r_fsm == ST_MUL) && done_t &&
                         (r_stg != STG_W'(STAGES - 1))) begin
                r_stg <= r_stg + 1'b1;
            end else if ((r_fsm == ST_MIXW) && done_x && !r_ch) begin
                // left path done, start the right path
                r_ch  <= 1'b1;
                r_stg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dry_l <= i_in.left_sample;
            r_dry_r <= right_src;
            r_x     <= t_state'(i_in.left_sample) <<< FRAC_W;
            r_yl    <= i_in.left_sample;
            r_yr    <= right_src;
        end else if ((r_fsm == ST_MUL) && done_t) begin
            r_x <= x_new;
        end else if ((r_fsm == ST_MIXW) && done_x) begin
            if (r_ch) begin
                r_yr <= y_out;
            end else begin
                r_yl <= y_out;
                r_x  <= t_state'(r_dry_r) <<< FRAC_W;
            end
        end
        if (out_load) begin
            r_out_l <= r_yl;
            r_out_r <= r_yr;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

endmodule

/* tb/cts_smoother_checker.sv */
`timescale 1ns / 1ps

module cts_smoother_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cts_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  cts_pkg::t_sample              i_left_sample,
    input  cts_pkg::t_sample              i_right_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  cts_pkg::t_sample              i_left_out,
    input  cts_pkg::t_sample              i_right_out,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import cts_pkg::*;

    // wide enough for any state times coefficient sum without overflow
    typedef logic signed [95:0] t_wide;

    typedef struct {
        t_sample left_out;
        t_sample right_out;
    } t_pair;

    localparam t_wide STATE_HI  = (t_wide'(1) <<< (STATE_W - 1)) - t_wide'(1);
    localparam t_wide STATE_LO  = -STATE_HI - t_wide'(1);
    localparam t_wide SAMPLE_HI = (t_wide'(1) <<< (SAMPLE_W - 1)) - t_wide'(1);
    localparam t_wide SAMPLE_LO = -SAMPLE_HI - t_wide'(1);
    localparam t_wide DECAY_K   = t_wide'(K0999);

    t_state            smooth_prev  [2][STAGES];
    t_state            smooth_trend [2][STAGES];
    logic [COEF_W-1:0] alpha_q;
    logic [COEF_W-1:0] beta_q;
    logic [MIX_W-1:0]  wet_q;
    logic              bypass_q;
    logic              mono_q;
    t_pair             expected_pairs [$];
    int                fails   = 0;
    int                checked = 0;

    function automatic t_state clip_state(input t_wide v);
        if (v > STATE_HI) return t_state'(STATE_HI);
        if (v < STATE_LO) return t_state'(STATE_LO);
        return t_state'(v);
    endfunction

    function automatic t_sample clip_sample(input t_wide v);
        if (v > SAMPLE_HI) return t_sample'(SAMPLE_HI);
        if (v < SAMPLE_LO) return t_sample'(SAMPLE_LO);
        return t_sample'(v);
    endfunction

    // exact weighted sum, one round half up
    function automatic t_wide round_blend(input t_wide v1, input t_wide c1,
                                          input t_wide v2, input t_wide c2, input int sh);
        t_wide acc;
        acc = v1 * c1 + v2 * c2 + (t_wide'(1) <<< (sh - 1));
        return acc >>> sh;
    endfunction

    // one channel through the stage cascade, then the wet/dry mix
    function automatic t_sample holt_path(input t_sample dry, input int ch,
                                          input t_wide a, input t_wide b, input t_wide w);
        t_wide  dry_fix;
        t_wide  x;
        t_wide  mix;
        t_state d;
        t_state t;
        t_state f;
        int     s;
        dry_fix = t_wide'(dry) <<< FRAC_W;
        x = dry_fix;
        for (s = 0; s < STAGES; s++) begin
            d = clip_state(x - t_wide'(smooth_prev[ch][s]));
            t = clip_state(round_blend(t_wide'(d), b, t_wide'(smooth_trend[ch][s]),
                                       DECAY_K - b, COEF_SH));
            f = clip_state(t_wide'(smooth_prev[ch][s]) + t_wide'(smooth_trend[ch][s]));
            x = t_wide'(clip_state(round_blend(x, a, t_wide'(f), DECAY_K - a, COEF_SH)));
            smooth_prev[ch][s]  = t_state'(x);
            smooth_trend[ch][s] = t;
        end
        mix = round_blend(x, w, dry_fix, t_wide'(WET_ONE) - w, MIX_SH);
        mix = (mix + (t_wide'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        return clip_sample(mix);
    endfunction

    function automatic t_pair predict_pair(input t_sample l, input t_sample r);
        t_pair   res;
        t_sample dr;
        t_wide   a;
        t_wide   b;
        t_wide   w;
        dr = mono_q ? l : r;
        a  = (alpha_q > COEF_ONE) ? t_wide'(COEF_ONE) : t_wide'(alpha_q);
        b  = (beta_q > COEF_ONE) ? t_wide'(COEF_ONE) : t_wide'(beta_q);
        w  = (wet_q > WET_ONE) ? t_wide'(WET_ONE) : t_wide'(wet_q);
        if (bypass_q || w == '0) begin
            res.left_out  = l;
            res.right_out = dr;
        end else begin
            res.left_out  = holt_path(l, 0, a, b, w);
            res.right_out = holt_path(dr, 1, a, b, w);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pair want;
        int    s;
        if (!i_rst_n) begin
            for (s = 0; s < STAGES; s++) begin
                smooth_prev[0][s]  = '0;
                smooth_prev[1][s]  = '0;
                smooth_trend[0][s] = '0;
                smooth_trend[1][s] = '0;
            end
            alpha_q  = '0;
            beta_q   = '0;
            wet_q    = WET_RESET;
            bypass_q = 1'b0;
            mono_q   = 1'b0;
            expected_pairs.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_pairs = {expected_pairs,
                                  predict_pair(i_left_sample, i_right_sample)};
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("result with nothing expected: left_out %0d right_out %0d",
                           i_left_out, i_right_out);
                    fails++;
                end else begin
                    want = expected_pairs.pop_front();
                    checked++;
                    if (i_left_out !== want.left_out) begin
                        $error("left_out mismatch: expected %0d, actual %0d",
                               want.left_out, i_left_out);
                        fails++;
                    end
                    if (i_right_out !== want.right_out) begin
                        $error("right_out mismatch: expected %0d, actual %0d",
                               want.right_out, i_right_out);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALPHA:  alpha_q  = i_cfg_data[COEF_W-1:0];
                    REG_BETA:   beta_q   = i_cfg_data[COEF_W-1:0];
                    REG_WET:    wet_q    = i_cfg_data[MIX_W-1:0];
                    REG_BYPASS: bypass_q = i_cfg_data[0];
                    REG_MONO:   mono_q   = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_pairs.size();
        o_checked    <= checked;
    end

endmodule

/* tb/cascaded_trend_smoother_stereo_core_test.sv */
`timescale 1ns / 1ps

module cascaded_trend_smoother_stereo_core_test;
    import cts_pkg::*;

    // timing of the run
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int SETTLE_CYCLES = 160;   // a bit more than one full item pass
    localparam int HOLD_CYCLES   = 3000;  // long output hold for the back-pressure phase
    localparam int PHASE_ITEMS   = 108;

    // an index the block does not decode, used to check writes there are harmless
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(REG_MONO) + CFG_IDX_W'(1);

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    cts_in_if  in_ch ();
    cts_out_if out_ch ();

    int      fail_count;
    int      pending;
    int      checked;
    int      send_idle_pct;   // only the main process reads it
    int      recv_stall_pct;  // read by the receiver process, so updated at the edge
    logic    long_hold;
    int      items_sent = 0;
    int      reg_writes = 0;
    int      phases_run = 0;
    t_sample left_walk  = '0;
    t_sample right_walk = '0;

    cascaded_trend_smoother_stereo_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // prediction and comparison live in the checker, it only reports back
    cts_smoother_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_left_sample  (in_ch.left_sample),
        .i_right_sample (in_ch.right_sample),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_left_out     (out_ch.left_out),
        .i_right_out    (out_ch.right_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 125 MHz clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: results stopped arriving, %0d still expected", pending);
        $display("Verification failed");
        $finish;
    end

    // output side: random stalls, or a solid hold while long_hold is up
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // one register write, we pulses for a single edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // offer one sample pair, with random idle cycles ahead of it
    task automatic push_sample(input t_sample l, input t_sample r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid        <= 1'b0;
            in_ch.left_sample  <= t_sample'($urandom);  // junk payload while idle
            in_ch.right_sample <= t_sample'($urandom);
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= l;
        in_ch.right_sample <= r;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // stop offering, let every expected result come out, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // a mix of full-scale noise, rail values, quiet audio and a slow random walk
    function automatic t_sample pick_sample(inout t_sample walk);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return t_sample'($urandom);
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 70) return t_sample'($urandom_range(0, 8191)) - t_sample'(4096);
        walk = walk + t_sample'($urandom_range(0, 4000)) - t_sample'(2000);
        return walk;
    endfunction

    // coefficients: zero, exactly one, anything the register holds, or inside (0, 1)
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(1, COEF_ONE - 1));
        endcase
    endfunction

    // fresh random settings, then a run of random samples under one idle pattern
    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        logic [MIX_W-1:0] wet;
        t_sample          l;
        t_sample          r;
        wait_idle();
        case ($urandom_range(0, 9))
            0:       wet = '0;
            1:       wet = WET_ONE;
            2:       wet = MIX_W'($urandom);
            default: wet = MIX_W'($urandom_range(1, WET_ONE - 1));
        endcase
        write_reg(REG_ALPHA, CFG_W'(pick_coef()));
        write_reg(REG_BETA, CFG_W'(pick_coef()));
        // upper bits beyond each register's width carry noise, they must be dropped
        write_reg(REG_WET, (CFG_W'($urandom) << MIX_W) | CFG_W'(wet));
        write_reg(REG_BYPASS, (CFG_W'($urandom) << 1) | CFG_W'($urandom_range(0, 7) == 0));
        write_reg(REG_MONO, (CFG_W'($urandom) << 1) | CFG_W'($urandom_range(0, 3) == 0));
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
        repeat (count) begin
            l = pick_sample(left_walk);
            r = pick_sample(right_walk);
            push_sample(l, r);
        end
        phases_run++;
    endtask

    initial begin
        int k;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.left_sample  <= '0;
        in_ch.right_sample <= '0;
        long_hold          <= 1'b0;
        recv_stall_pct     <= 0;
        send_idle_pct       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero coefficients, half wet
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample('0, '1);

        // full coefficients and full wet, rail-to-rail steps drive the state into saturation
        wait_idle();
        write_reg(REG_ALPHA, CFG_W'(COEF_ONE));
        write_reg(REG_BETA, CFG_W'(COEF_ONE));
        write_reg(REG_WET, CFG_W'(WET_ONE));
        for (k = 0; k < 6; k++) begin
            push_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX, (k % 2) ? SAMPLE_MAX : SAMPLE_MIN);
        end

        // coefficients and wet above one get clamped, 0.999 - coef goes negative
        wait_idle();
        write_reg(REG_ALPHA, '1);
        write_reg(REG_BETA, '1);
        write_reg(REG_WET, CFG_W'({MIX_W{1'b1}}));
        push_sample(t_sample'(1), '1);
        push_sample('1, t_sample'(1));
        push_sample(t_sample'(12345), t_sample'(-54321));

        // bypass passes samples through and freezes the state
        wait_idle();
        write_reg(REG_BYPASS, CFG_W'(1));
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(t_sample'($urandom), t_sample'($urandom));

        // zero wet acts like bypass
        wait_idle();
        write_reg(REG_BYPASS, '0);
        write_reg(REG_WET, '0);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(t_sample'($urandom), t_sample'($urandom));

        // mono: right input ignored, right path fed from left
        wait_idle();
        write_reg(REG_WET, CFG_W'(40000));
        write_reg(REG_ALPHA, CFG_W'(5000000));
        write_reg(REG_BETA, CFG_W'(1000000));
        write_reg(REG_MONO, CFG_W'(1));
        write_reg(REG_UNUSED, CFG_W'($urandom));
        push_sample(t_sample'(1000000), SAMPLE_MIN);
        push_sample(t_sample'(-2000000), SAMPLE_MAX);
        push_sample(t_sample'($urandom), t_sample'($urandom));
        wait_idle();
        write_reg(REG_MONO, '0);

        // back-pressure: output held for a long stretch while inputs keep coming
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        fork
            begin
                long_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
            begin
                repeat (24) push_sample(pick_sample(left_walk), pick_sample(right_walk));
            end
        join

        // random part, each idle pattern twice with fresh settings
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(61, 0, PHASE_ITEMS);
        run_phase(0, 61, PHASE_ITEMS);
        run_phase(15, 15, PHASE_ITEMS);
        run_phase(15, 15, PHASE_ITEMS);
        run_phase(0, 61, PHASE_ITEMS);
        run_phase(61, 0, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        wait_idle();
        $display("summary: %0d sample pairs sent, %0d result pairs checked, %0d register writes",
                 items_sent, checked, reg_writes);
        $display("summary: directed rails, clamped settings, bypass, zero wet, mono, long hold,",
                 " %0d random phases", phases_run);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
